>>> rtl/key_click_gesture_detector_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef KEY_CLICK_GESTURE_DETECTOR_ASSERT_SVH
`define KEY_CLICK_GESTURE_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KCGD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("kcgd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define KCGD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("kcgd assertion failed");

`endif

>>> rtl/kcgd_pkg.sv
package kcgd_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned MsW     = 16;
  localparam int unsigned KeyIdW  = 4;
  localparam int unsigned FlagW   = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned ReqW    = 2;

  typedef enum logic [ReqW-1:0] {
    REQ_UPDATE = 2'd0,
    REQ_FETCH  = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_CLICK  = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE  = 3'd0,
    CFG_LONG_MS   = 3'd1,
    CFG_DOUBLE_MS = 3'd2,
    CFG_PRESS_LVL = 3'd3,
    CFG_CLICK_EN  = 3'd4,
    CFG_DOUBLE_EN = 3'd5,
    CFG_LONG_EN   = 3'd6
  } cfg_idx_e;

  localparam logic [FlagW-1:0] FlagClick  = 3'b001;
  localparam logic [FlagW-1:0] FlagDouble = 3'b010;
  localparam logic [FlagW-1:0] FlagLong   = 3'b100;

  typedef struct packed {
    logic [MsW-1:0] debounce_ms;
    logic [MsW-1:0] long_press_ms;
    logic [MsW-1:0] double_click_ms;
    logic           pressed_level;
    logic           click_enable;
    logic           double_click_enable;
    logic           long_press_enable;
  } cfg_t;

  typedef struct packed {
    logic             debounced_level;
    logic             raw_level;
    logic [TimeW-1:0] debounce_stamp;
    logic [TimeW-1:0] press_stamp;
    logic [TimeW-1:0] click_stamp;
    logic             click_waiting;
    logic             long_reported;
    logic [FlagW-1:0] sticky_flags;
  } key_rec_t;

  // Keys come out of reset released: the raw level is high.
  localparam key_rec_t KeyRecReset = '{
    debounced_level: 1'b1,
    raw_level:       1'b1,
    debounce_stamp:  '0,
    press_stamp:     '0,
    click_stamp:     '0,
    click_waiting:   1'b0,
    long_reported:   1'b0,
    sticky_flags:    '0
  };

endpackage

>>> rtl/kcgd_cfg_regs.sv
module kcgd_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [kcgd_pkg::CfgIdxW-1:0]   cfg_addr_i,
  input  logic [kcgd_pkg::MsW-1:0]       cfg_wdata_i,
  output kcgd_pkg::cfg_t                 cfg_o
);

  kcgd_pkg::cfg_t cfg_q;
  kcgd_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        kcgd_pkg::CFG_DEBOUNCE:  cfg_d.debounce_ms         = cfg_wdata_i;
        kcgd_pkg::CFG_LONG_MS:   cfg_d.long_press_ms       = cfg_wdata_i;
        kcgd_pkg::CFG_DOUBLE_MS: cfg_d.double_click_ms     = cfg_wdata_i;
        kcgd_pkg::CFG_PRESS_LVL: cfg_d.pressed_level       = cfg_wdata_i[0];
        kcgd_pkg::CFG_CLICK_EN:  cfg_d.click_enable        = cfg_wdata_i[0];
        kcgd_pkg::CFG_DOUBLE_EN: cfg_d.double_click_enable = cfg_wdata_i[0];
        kcgd_pkg::CFG_LONG_EN:   cfg_d.long_press_enable   = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms         <= 16'd20;
      cfg_q.long_press_ms       <= 16'd1000;
      cfg_q.double_click_ms     <= 16'd300;
      cfg_q.pressed_level       <= 1'b0;
      cfg_q.click_enable        <= 1'b1;
      cfg_q.double_click_enable <= 1'b1;
      cfg_q.long_press_enable   <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/kcgd_key_update.sv
module kcgd_key_update (
  input  kcgd_pkg::cfg_t                   cfg_i,
  input  kcgd_pkg::key_rec_t               rec_i,
  input  logic [kcgd_pkg::ReqW-1:0]        req_i,
  input  logic                             level_i,
  input  logic [kcgd_pkg::TimeW-1:0]       now_i,
  input  logic [kcgd_pkg::FlagW-1:0]       mask_i,
  output kcgd_pkg::key_rec_t               rec_o,
  output kcgd_pkg::event_e                 event_o,
  output logic [kcgd_pkg::FlagW-1:0]       flags_o,
  output logic                             pressed_o
);

  logic [kcgd_pkg::TimeW-1:0] db_diff;
  logic [kcgd_pkg::TimeW-1:0] press_diff;
  logic [kcgd_pkg::TimeW-1:0] click_diff;
  logic                       level_new;
  logic                       db_ok;
  logic                       changed;
  logic                       press_edge;
  logic                       long_ok;
  logic                       click_expired;
  logic                       is_pressed;

  // All time differences wrap modulo 2^32.
  assign db_diff    = now_i - rec_i.debounce_stamp;
  assign press_diff = now_i - rec_i.press_stamp;
  assign click_diff = now_i - rec_i.click_stamp;

  assign level_new = level_i != rec_i.raw_level;
  // A fresh level restarts the debounce stamp at now, so the elapsed time is zero.
  assign db_ok = level_new ? (cfg_i.debounce_ms == '0)
                           : (db_diff >= {16'd0, cfg_i.debounce_ms});
  assign changed    = db_ok && (level_i != rec_i.debounced_level);
  assign press_edge = changed && (level_i == cfg_i.pressed_level);
  assign long_ok    = press_edge ? (cfg_i.long_press_ms == '0)
                                 : (press_diff >= {16'd0, cfg_i.long_press_ms});
  assign click_expired = rec_i.click_waiting &&
                         (click_diff >= {16'd0, cfg_i.double_click_ms});

  always_comb begin
    rec_o      = rec_i;
    event_o    = kcgd_pkg::EV_NONE;
    flags_o    = rec_i.sticky_flags;
    is_pressed = rec_i.debounced_level == cfg_i.pressed_level;
    case (req_i)
      kcgd_pkg::REQ_UPDATE: begin
        if (level_new) begin
          rec_o.raw_level      = level_i;
          rec_o.debounce_stamp = now_i;
        end
        if (changed) begin
          rec_o.debounced_level = level_i;
          if (press_edge) begin
            rec_o.press_stamp   = now_i;
            rec_o.long_reported = 1'b0;
          end else if (rec_i.long_reported) begin
            // The release that ends a long press is silent.
            rec_o.long_reported = 1'b0;
            rec_o.click_waiting = 1'b0;
          end else if (cfg_i.double_click_enable) begin
            if (click_expired) begin
              if (cfg_i.click_enable) begin
                event_o            = kcgd_pkg::EV_CLICK;
                rec_o.sticky_flags = rec_o.sticky_flags | kcgd_pkg::FlagClick;
              end
              rec_o.click_waiting = 1'b0;
            end
            if (!rec_o.click_waiting) begin
              rec_o.click_waiting = 1'b1;
              rec_o.click_stamp   = now_i;
            end else begin
              event_o             = kcgd_pkg::EV_DOUBLE;
              rec_o.sticky_flags  = rec_o.sticky_flags | kcgd_pkg::FlagDouble;
              rec_o.click_waiting = 1'b0;
            end
          end else if (cfg_i.click_enable) begin
            event_o            = kcgd_pkg::EV_CLICK;
            rec_o.sticky_flags = rec_o.sticky_flags | kcgd_pkg::FlagClick;
          end
        end
        is_pressed = rec_o.debounced_level == cfg_i.pressed_level;
        if (cfg_i.long_press_enable && is_pressed && !rec_o.long_reported && long_ok) begin
          rec_o.long_reported = 1'b1;
          rec_o.click_waiting = 1'b0;
          event_o             = kcgd_pkg::EV_LONG;
          rec_o.sticky_flags  = rec_o.sticky_flags | kcgd_pkg::FlagLong;
        end
        // A pending single click times out while the key stays released.
        if (!changed && !is_pressed && cfg_i.double_click_enable && click_expired) begin
          if (cfg_i.click_enable) begin
            event_o            = kcgd_pkg::EV_CLICK;
            rec_o.sticky_flags = rec_o.sticky_flags | kcgd_pkg::FlagClick;
          end
          rec_o.click_waiting = 1'b0;
        end
        flags_o = rec_o.sticky_flags;
      end
      kcgd_pkg::REQ_FETCH: begin
        rec_o.sticky_flags = '0;
      end
      kcgd_pkg::REQ_CLEAR: begin
        rec_o.sticky_flags = rec_i.sticky_flags & ~mask_i;
        flags_o            = rec_o.sticky_flags;
      end
      default: ;
    endcase
  end

  assign pressed_o = is_pressed;

endmodule

>>> rtl/key_click_gesture_detector.sv
// Channel  | Direction | Handshake                  | Word
// in       | input     | in_valid_i / in_ready_o    | req_type, key_id, pin_level, now_ms, clr_mask
// out      | output    | out_valid_o / out_ready_i  | out_key_id, pressed, event_res, key_flags
// cfg      | input     | cfg_we_i (always taken)    | cfg_addr_i, cfg_wdata_i
//
// One word is accepted per cycle while in_ready_o is high. Its key record is read, updated
// and written back while the word sits in the input register, and its result is then
// registered in the result register, from which the output channel presents it.
// Reset puts every key in the released state with cleared flags and restores register defaults.
// A stalled output holds its word; the input stalls only while both the input register and
// the result register hold words and the output is not taken.
module key_click_gesture_detector #(
  parameter int unsigned KEY_COUNT = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kcgd_pkg::CfgIdxW-1:0]  cfg_addr_i,
  input  logic [kcgd_pkg::MsW-1:0]      cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [kcgd_pkg::ReqW-1:0]     req_type_i,
  input  logic [kcgd_pkg::KeyIdW-1:0]   key_id_i,
  input  logic                          pin_level_i,
  input  logic [kcgd_pkg::TimeW-1:0]    now_ms_i,
  input  logic [kcgd_pkg::FlagW-1:0]    clr_mask_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [kcgd_pkg::KeyIdW-1:0]   out_key_id_o,
  output logic                          pressed_o,
  output logic [1:0]                    event_res_o,
  output logic [kcgd_pkg::FlagW-1:0]    key_flags_o
);

  localparam int unsigned KeyIdxW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  kcgd_pkg::cfg_t cfg;

  logic                          in_valid_q;
  logic [kcgd_pkg::ReqW-1:0]     req_q;
  logic [kcgd_pkg::KeyIdW-1:0]   key_q;
  logic                          level_q;
  logic [kcgd_pkg::TimeW-1:0]    now_q;
  logic [kcgd_pkg::FlagW-1:0]    mask_q;

  logic                          out_valid_q;
  logic [kcgd_pkg::KeyIdW-1:0]   out_key_q;
  logic                          out_pressed_q;
  logic [1:0]                    out_event_q;
  logic [kcgd_pkg::FlagW-1:0]    out_flags_q;

  kcgd_pkg::key_rec_t            keys_q [KEY_COUNT];
  kcgd_pkg::key_rec_t            rec_cur;
  kcgd_pkg::key_rec_t            rec_nxt;
  kcgd_pkg::event_e              upd_event;
  logic [kcgd_pkg::FlagW-1:0]    upd_flags;
  logic                          upd_pressed;

  logic                          advance;
  logic                          in_range;
  logic [KeyIdxW-1:0]            key_idx;

  kcgd_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The result register moves when it is empty or being taken.
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q   <= req_type_i;
      key_q   <= key_id_i;
      level_q <= pin_level_i;
      now_q   <= now_ms_i;
      mask_q  <= clr_mask_i;
    end
  end

  assign in_range = {1'b0, key_q} < (kcgd_pkg::KeyIdW + 1)'(KEY_COUNT);
  assign key_idx  = KeyIdxW'(key_q);
  assign rec_cur  = in_range ? keys_q[key_idx] : kcgd_pkg::KeyRecReset;

  kcgd_key_update u_key_update (
    .cfg_i     (cfg),
    .rec_i     (rec_cur),
    .req_i     (req_q),
    .level_i   (level_q),
    .now_i     (now_q),
    .mask_i    (mask_q),
    .rec_o     (rec_nxt),
    .event_o   (upd_event),
    .flags_o   (upd_flags),
    .pressed_o (upd_pressed)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KEY_COUNT; i++) begin
        keys_q[i] <= kcgd_pkg::KeyRecReset;
      end
    end else if (advance && in_valid_q && in_range) begin
      keys_q[key_idx] <= rec_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  // A key beyond the key count reports zeros apart from its index.
  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_key_q     <= key_q;
      out_pressed_q <= in_range && upd_pressed;
      out_event_q   <= in_range ? upd_event : kcgd_pkg::EV_NONE;
      out_flags_q   <= in_range ? upd_flags : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_key_id_o = out_key_q;
  assign pressed_o    = out_pressed_q;
  assign event_res_o  = out_event_q;
  assign key_flags_o  = out_flags_q;

endmodule

>>> rtl/kcgd_checker.sv
`include "key_click_gesture_detector_assert.svh"

module kcgd_checker #(
  parameter int unsigned KEY_COUNT = 4
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [kcgd_pkg::KeyIdW-1:0]   out_key_id_o,
  input logic                          pressed_o,
  input logic [1:0]                    event_res_o,
  input logic [kcgd_pkg::FlagW-1:0]    key_flags_o
);

  logic                                          key_out_of_range;
  logic                                          event_flag_seen;
  logic                                          bad_key_quiet;
  logic [kcgd_pkg::KeyIdW+kcgd_pkg::FlagW+2:0]   out_word;

  assign key_out_of_range = {1'b0, out_key_id_o} >= (kcgd_pkg::KeyIdW + 1)'(KEY_COUNT);

  // A raised event always leaves its sticky flag set in the same word.
  assign event_flag_seen =
      (event_res_o == kcgd_pkg::EV_NONE) ||
      ((event_res_o == kcgd_pkg::EV_CLICK)  && key_flags_o[0]) ||
      ((event_res_o == kcgd_pkg::EV_DOUBLE) && key_flags_o[1]) ||
      ((event_res_o == kcgd_pkg::EV_LONG)   && key_flags_o[2]);

  assign bad_key_quiet = !pressed_o && (event_res_o == kcgd_pkg::EV_NONE) &&
                         (key_flags_o == '0);

  assign out_word = {out_key_id_o, pressed_o, event_res_o, key_flags_o};

  `KCGD_ASSERT_NOW(a_event_has_flag, clk_i, rst_ni, out_valid_o, event_flag_seen)

  `KCGD_ASSERT_NOW(a_bad_key_quiet, clk_i, rst_ni, out_valid_o && key_out_of_range, bad_key_quiet)

  `KCGD_ASSERT_NOW(a_ready_only_on_stall, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)

  `KCGD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_word))

endmodule

bind key_click_gesture_detector kcgd_checker #(.KEY_COUNT(KEY_COUNT)) u_kcgd_checker (.*);

>>> test/tb_key_click_gesture_detector.sv
`timescale 1ns / 1ps

module tb_key_click_gesture_detector;
  import kcgd_pkg::*;

  localparam int unsigned KeyCount   = 4;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned PhaseWords = 270;
  localparam logic [ReqW-1:0] ReqUnused = 2'd3;

  typedef struct {
    logic [KeyIdW-1:0] key;
    logic              pressed;
    event_e            ev;
    logic [FlagW-1:0]  flags;
  } key_result_t;

  class gesture_scoreboard;
    cfg_t        cfg;
    key_rec_t    recs[KeyCount];
    key_result_t due_q[$];
    int unsigned mismatches;

    function new();
      cfg = '{debounce_ms: 16'd20, long_press_ms: 16'd1000, double_click_ms: 16'd300,
              pressed_level: 1'b0, click_enable: 1'b1, double_click_enable: 1'b1,
              long_press_enable: 1'b1};
      foreach (recs[i]) recs[i] = KeyRecReset;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [MsW-1:0] val);
      case (idx)
        CFG_DEBOUNCE:  cfg.debounce_ms = val;
        CFG_LONG_MS:   cfg.long_press_ms = val;
        CFG_DOUBLE_MS: cfg.double_click_ms = val;
        CFG_PRESS_LVL: cfg.pressed_level = val[0];
        CFG_CLICK_EN:  cfg.click_enable = val[0];
        CFG_DOUBLE_EN: cfg.double_click_enable = val[0];
        CFG_LONG_EN:   cfg.long_press_enable = val[0];
        default: ;
      endcase
    endfunction

    // Stored levels are raw pin levels, so the polarity is applied on every read.
    function logic held(int k);
      return recs[k].debounced_level == cfg.pressed_level;
    endfunction

    function logic [TimeW-1:0] since(logic [TimeW-1:0] now, logic [TimeW-1:0] stamp);
      return now - stamp;
    endfunction

    function event_e raise(int k, event_e ev);
      case (ev)
        EV_CLICK:  recs[k].sticky_flags |= FlagClick;
        EV_DOUBLE: recs[k].sticky_flags |= FlagDouble;
        EV_LONG:   recs[k].sticky_flags |= FlagLong;
        default: ;
      endcase
      return ev;
    endfunction

    function event_e settle_release(int k, logic [TimeW-1:0] now);
      event_e ev;
      ev = EV_NONE;
      if (recs[k].long_reported) begin
        recs[k].long_reported = 1'b0;
        recs[k].click_waiting = 1'b0;
        return EV_NONE;
      end
      if (cfg.double_click_enable) begin
        // A stale first click is reported on its own before this release opens a new window.
        if (recs[k].click_waiting &&
            since(now, recs[k].click_stamp) >= cfg.double_click_ms) begin
          if (cfg.click_enable) ev = raise(k, EV_CLICK);
          recs[k].click_waiting = 1'b0;
        end
        if (!recs[k].click_waiting) begin
          recs[k].click_waiting = 1'b1;
          recs[k].click_stamp = now;
        end else begin
          ev = raise(k, EV_DOUBLE);
          recs[k].click_waiting = 1'b0;
        end
      end else if (cfg.click_enable) begin
        ev = raise(k, EV_CLICK);
      end
      return ev;
    endfunction

    function event_e sample_level(int k, logic lvl, logic [TimeW-1:0] now);
      event_e ev;
      logic   moved;
      ev = EV_NONE;
      moved = 1'b0;
      if (lvl != recs[k].raw_level) begin
        recs[k].raw_level = lvl;
        recs[k].debounce_stamp = now;
      end
      if (since(now, recs[k].debounce_stamp) >= cfg.debounce_ms &&
          lvl != recs[k].debounced_level) begin
        recs[k].debounced_level = lvl;
        moved = 1'b1;
        if (held(k)) begin
          recs[k].press_stamp = now;
          recs[k].long_reported = 1'b0;
        end else begin
          ev = settle_release(k, now);
        end
      end
      if (cfg.long_press_enable && held(k) && !recs[k].long_reported &&
          since(now, recs[k].press_stamp) >= cfg.long_press_ms) begin
        recs[k].long_reported = 1'b1;
        recs[k].click_waiting = 1'b0;
        ev = raise(k, EV_LONG);
      end
      if (!moved && !held(k) && cfg.double_click_enable && recs[k].click_waiting &&
          since(now, recs[k].click_stamp) >= cfg.double_click_ms) begin
        if (cfg.click_enable) ev = raise(k, EV_CLICK);
        recs[k].click_waiting = 1'b0;
      end
      return ev;
    endfunction

    function void note_word(logic [ReqW-1:0] req, logic [KeyIdW-1:0] key, logic lvl,
                            logic [TimeW-1:0] now, logic [FlagW-1:0] mask);
      key_result_t r;
      int          k;
      r.key = key;
      r.pressed = 1'b0;
      r.ev = EV_NONE;
      r.flags = '0;
      if (key < KeyCount) begin
        k = key;
        case (req)
          REQ_UPDATE: begin
            r.ev = sample_level(k, lvl, now);
            r.flags = recs[k].sticky_flags;
          end
          REQ_FETCH: begin
            r.flags = recs[k].sticky_flags;
            recs[k].sticky_flags = '0;
          end
          REQ_CLEAR: begin
            recs[k].sticky_flags &= ~mask;
            r.flags = recs[k].sticky_flags;
          end
          default: r.flags = recs[k].sticky_flags;
        endcase
        r.pressed = held(k);
      end
      due_q.push_back(r);
    endfunction

    function void check_result(logic [KeyIdW-1:0] key, logic pressed, logic [1:0] ev,
                               logic [FlagW-1:0] flags);
      key_result_t want;
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: key %0d pressed %b event %0d flags %b",
                   key, pressed, ev, flags);
        return;
      end
      want = due_q.pop_front();
      if (key !== want.key || pressed !== want.pressed || ev !== want.ev ||
          flags !== want.flags) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected key %0d pressed %b event %0d flags %b, ",
                    "got key %0d pressed %b event %0d flags %b"},
                   want.key, want.pressed, want.ev, want.flags, key, pressed, ev, flags);
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_addr_i = '0;
  logic [MsW-1:0]      cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [ReqW-1:0]     req_type_i = '0;
  logic [KeyIdW-1:0]   key_id_i = '0;
  logic                pin_level_i = 1'b1;
  logic [TimeW-1:0]    now_ms_i = '0;
  logic [FlagW-1:0]    clr_mask_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b1;
  logic [KeyIdW-1:0]   out_key_id_o;
  logic                pressed_o;
  logic [1:0]          event_res_o;
  logic [FlagW-1:0]    key_flags_o;

  gesture_scoreboard   sb;
  logic                calm = 1'b0;
  int unsigned         words_sent = 0;
  int unsigned         stall_cycles = 0;
  logic [TimeW-1:0]    key_time[KeyCount];

  key_click_gesture_detector #(
    .KEY_COUNT(KeyCount)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .key_id_i     (key_id_i),
    .pin_level_i  (pin_level_i),
    .now_ms_i     (now_ms_i),
    .clr_mask_i   (clr_mask_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_key_id_o (out_key_id_o),
    .pressed_o    (pressed_o),
    .event_res_o  (event_res_o),
    .key_flags_o  (key_flags_o)
  );

  always #10 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 37);
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      sb.note_word(req_type_i, key_id_i, pin_level_i, now_ms_i, clr_mask_i);
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(out_key_id_o, pressed_o, event_res_o, key_flags_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_word(logic [ReqW-1:0] req, logic [KeyIdW-1:0] key, logic lvl,
                           logic [TimeW-1:0] now, logic [FlagW-1:0] mask);
    @(negedge clk_i);
    // Each cycle is left idle with the same chance, so idle cycles make up that share.
    while (!calm && $urandom_range(99) < 37) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    key_id_i    <= key;
    pin_level_i <= lvl;
    now_ms_i    <= now;
    clr_mask_i  <= mask;
    do @(posedge clk_i); while (!in_ready_o);
    if (key < KeyCount) words_sent++;
  endtask

  task automatic set_reg(cfg_idx_e idx, logic [MsW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // Registers change only once the pipeline has emptied.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic int unsigned under(int unsigned lim);
    return (lim == 0) ? 0 : $urandom_range(0, lim - 1);
  endfunction

  function automatic int unsigned beyond(int unsigned lim);
    return lim + $urandom_range(0, 40);
  endfunction

  task automatic tick(int k, logic lvl, int unsigned delta);
    key_time[k] += delta;
    send_word(REQ_UPDATE, 4'(k), lvl, key_time[k], 3'($urandom_range(7)));
  endtask

  // A few bounces shorter than the hold time, then the level held long enough to count.
  task automatic settle_to(int k, logic lvl);
    int unsigned deb;
    deb = sb.cfg.debounce_ms;
    repeat ($urandom_range(0, 3)) tick(k, 1'($urandom_range(1)), under(deb));
    tick(k, lvl, under(deb));
    tick(k, lvl, beyond(deb));
  endtask

  task automatic hold_level(int k, logic lvl, int unsigned total);
    int unsigned n;
    n = $urandom_range(1, 3);
    repeat (n - 1) tick(k, lvl, total / n);
    tick(k, lvl, total - (n - 1) * (total / n));
  endtask

  task automatic play_gesture(int k);
    logic        press_lvl;
    int unsigned lng;
    int unsigned dbl;
    press_lvl = sb.cfg.pressed_level;
    lng = sb.cfg.long_press_ms;
    dbl = sb.cfg.double_click_ms;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        settle_to(k, press_lvl);
        hold_level(k, press_lvl, under(lng));
        settle_to(k, ~press_lvl);
        hold_level(k, ~press_lvl, $urandom_range(1) ? beyond(dbl) : under(dbl));
      end
      3, 4: begin
        settle_to(k, press_lvl);
        tick(k, press_lvl, under(lng / 4));
        settle_to(k, ~press_lvl);
        settle_to(k, press_lvl);
        settle_to(k, ~press_lvl);
        hold_level(k, ~press_lvl, beyond(dbl));
      end
      5: begin
        settle_to(k, press_lvl);
        hold_level(k, press_lvl, beyond(lng));
        if ($urandom_range(1)) tick(k, press_lvl, under(lng + 1));
        settle_to(k, ~press_lvl);
      end
      6: begin
        repeat ($urandom_range(2, 6))
          tick(k, 1'($urandom_range(1)),
               $urandom_range(3) == 0 ? $urandom : under(sb.cfg.debounce_ms + 2));
      end
      7: begin
        case ($urandom_range(0, 2))
          0: send_word(REQ_FETCH, 4'($urandom_range(0, KeyCount - 1)), 1'($urandom_range(1)),
                       $urandom, 3'($urandom_range(7)));
          1: send_word(REQ_CLEAR, 4'($urandom_range(0, KeyCount - 1)), 1'($urandom_range(1)),
                       $urandom, 3'($urandom_range(7)));
          default: send_word(ReqUnused, 4'($urandom_range(0, KeyCount - 1)),
                             1'($urandom_range(1)), $urandom, 3'($urandom_range(7)));
        endcase
      end
      8: send_word(2'($urandom_range(3)), 4'($urandom_range(KeyCount, 15)),
                   1'($urandom_range(1)), $urandom, 3'($urandom_range(7)));
      default: tick(k, 1'($urandom_range(1)), $urandom);
    endcase
  endtask

  task automatic apply_setting(int which);
    cfg_t c;
    case (which)
      1: c = '{debounce_ms: '0, long_press_ms: '0, double_click_ms: '0, pressed_level: 1'b1,
               click_enable: 1'b1, double_click_enable: 1'b1, long_press_enable: 1'b1};
      2: c = '{debounce_ms: '1, long_press_ms: '1, double_click_ms: '1, pressed_level: 1'b0,
               click_enable: 1'b1, double_click_enable: 1'b1, long_press_enable: 1'b1};
      3: c = '{debounce_ms: 16'($urandom_range(0, 30)),
               long_press_ms: 16'($urandom_range(100, 600)),
               double_click_ms: 16'($urandom_range(100, 400)),
               pressed_level: 1'($urandom_range(1)), click_enable: 1'($urandom_range(1)),
               double_click_enable: 1'($urandom_range(1)),
               long_press_enable: 1'($urandom_range(1))};
      4: c = '{debounce_ms: 16'd5, long_press_ms: 16'd200, double_click_ms: 16'd150,
               pressed_level: 1'b1, click_enable: 1'b1, double_click_enable: 1'b0,
               long_press_enable: 1'b1};
      5: c = '{debounce_ms: 16'd10, long_press_ms: 16'd300, double_click_ms: 16'd200,
               pressed_level: 1'b0, click_enable: 1'b0, double_click_enable: 1'b1,
               long_press_enable: 1'b0};
      default: c = '{debounce_ms: 16'($urandom), long_press_ms: 16'($urandom),
                     double_click_ms: 16'($urandom), pressed_level: 1'($urandom_range(1)),
                     click_enable: 1'($urandom_range(1)),
                     double_click_enable: 1'($urandom_range(1)),
                     long_press_enable: 1'($urandom_range(1))};
    endcase
    set_reg(CFG_DEBOUNCE, c.debounce_ms);
    set_reg(CFG_LONG_MS, c.long_press_ms);
    set_reg(CFG_DOUBLE_MS, c.double_click_ms);
    set_reg(CFG_PRESS_LVL, MsW'(c.pressed_level));
    set_reg(CFG_CLICK_EN, MsW'(c.click_enable));
    set_reg(CFG_DOUBLE_EN, MsW'(c.double_click_enable));
    set_reg(CFG_LONG_EN, MsW'(c.long_press_enable));
  endtask

  initial begin
    int unsigned goal;
    sb = new();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: pressed is low, 20 ms hold, 1000 ms long press, 300 ms window.
    // The press settles across the timestamp wrap.
    send_word(REQ_UPDATE, 4'd0, 1'b0, 32'hFFFF_FFF0, 3'd0);
    send_word(REQ_UPDATE, 4'd0, 1'b0, 32'h0000_0008, 3'd7);
    send_word(REQ_UPDATE, 4'd0, 1'b1, 32'h0000_0010, 3'd0);
    send_word(REQ_UPDATE, 4'd0, 1'b1, 32'h0000_0030, 3'd0);
    send_word(REQ_UPDATE, 4'd0, 1'b0, 32'h0000_0040, 3'd0);
    send_word(REQ_UPDATE, 4'd0, 1'b0, 32'h0000_0060, 3'd0);
    send_word(REQ_UPDATE, 4'd0, 1'b1, 32'h0000_0070, 3'd0);
    send_word(REQ_UPDATE, 4'd0, 1'b1, 32'h0000_0090, 3'd0);
    // Long press, then a release that reports nothing.
    send_word(REQ_UPDATE, 4'd0, 1'b0, 32'h0000_0100, 3'd0);
    send_word(REQ_UPDATE, 4'd0, 1'b0, 32'h0000_0120, 3'd0);
    send_word(REQ_UPDATE, 4'd0, 1'b0, 32'h0000_0600, 3'd0);
    send_word(REQ_UPDATE, 4'd0, 1'b1, 32'h0000_0610, 3'd0);
    send_word(REQ_UPDATE, 4'd0, 1'b1, 32'h0000_0630, 3'd0);
    // A lone click that expires into a single click while released.
    send_word(REQ_UPDATE, 4'd0, 1'b0, 32'h0000_0700, 3'd0);
    send_word(REQ_UPDATE, 4'd0, 1'b0, 32'h0000_0720, 3'd0);
    send_word(REQ_UPDATE, 4'd0, 1'b1, 32'h0000_0730, 3'd0);
    send_word(REQ_UPDATE, 4'd0, 1'b1, 32'h0000_0750, 3'd0);
    send_word(REQ_UPDATE, 4'd0, 1'b1, 32'hFFFF_FFFF, 3'd0);
    send_word(REQ_CLEAR, 4'd0, 1'b0, 32'd0, 3'b001);
    send_word(REQ_FETCH, 4'd0, 1'b1, 32'hFFFF_FFFF, 3'b111);
    send_word(ReqUnused, 4'd0, 1'b0, 32'd0, 3'd0);
    // A bounce on key 1 that never settles.
    send_word(REQ_UPDATE, 4'd1, 1'b0, 32'd0, 3'd0);
    send_word(REQ_UPDATE, 4'd1, 1'b1, 32'd5, 3'd0);
    send_word(REQ_UPDATE, 4'd15, 1'b1, 32'hFFFF_FFFF, 3'b111);
    send_word(REQ_FETCH, 4'(KeyCount), 1'b0, 32'd0, 3'd0);
    send_word(REQ_CLEAR, 4'(KeyCount - 1), 1'b1, 32'd0, 3'b111);

    foreach (key_time[i]) key_time[i] = $urandom_range(1) ? 32'hFFFF_0000 : $urandom;
    goal = words_sent;
    for (int phase = 1; phase <= 6; phase++) begin
      drain();
      apply_setting(phase);
      calm = (phase == 3);
      goal += PhaseWords;
      while (words_sent < goal) play_gesture($urandom_range(0, KeyCount - 1));
    end
    calm = 1'b0;
    drain();

    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/kcgd_pkg.sv
rtl/kcgd_cfg_regs.sv
rtl/kcgd_key_update.sv
rtl/key_click_gesture_detector.sv
rtl/kcgd_checker.sv
test/tb_key_click_gesture_detector.sv
